>>> rtl/core/asrms_pkg.sv
// Shared types, sizes and register indexes for the audio RMS level meter.
package asrms_pkg;

   // Frame length and the widths that follow from it. The frame length is a
   // power of two, so the mean square is the frame sum shifted right by POS_W.
   localparam int FRAME_SAMPLES = 1024;
   localparam int POS_W         = $clog2(FRAME_SAMPLES);
   localparam int SAMPLE_W      = 12;
   localparam int SQUARE_W      = 2 * SAMPLE_W;
   localparam int SUM_W         = SQUARE_W + POS_W;

   // The square root yields one bit per step, as does the level division.
   localparam int ROOT_STEPS    = SAMPLE_W;
   localparam int LEVEL_STEPS   = SAMPLE_W;
   localparam int CNT_W         = $clog2(ROOT_STEPS);

   // Smoothing factor format.
   localparam int ALPHA_W       = 9;
   localparam int ALPHA_ONE     = 256;
   localparam int SMOOTH_W      = SAMPLE_W + ALPHA_W;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   // Configuration port.
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_SMOOTHING   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_ALPHA    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_COMPRESSION = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPRESS_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTENSITY_STEP     = 3'd4;

   // Register file contents as seen by the front and the back.
   typedef struct packed {
      logic                enable_smoothing;
      logic [ALPHA_W-1:0]  smoothing_alpha;
      logic                enable_compression;
      logic [SAMPLE_W-1:0] compress_threshold;
      logic [SAMPLE_W-1:0] intensity_step;
   } cfg_type;

   // One queued request after smoothing.
   typedef struct packed {
      logic [SAMPLE_W-1:0] smoothed;
      logic                last;
   } entry_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_ROOT,
      BK_LEVEL
   } back_state_type;

endpackage

>>> rtl/core/asrms_front.sv
// Front end: accepts requests, applies the smoothing filter and tracks frame position.
module asrms_front (
   input  logic                                clock,
   input  logic                                reset,
   input  asrms_pkg::cfg_type                  cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [asrms_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                                q_full,
   output logic                                q_push,
   output asrms_pkg::entry_type                q_entry
);

   logic [asrms_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic [asrms_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [asrms_pkg::ALPHA_W-1:0]  alpha_sat;
   logic [asrms_pkg::ALPHA_W-1:0]  alpha_inv;
   logic [asrms_pkg::SMOOTH_W-1:0] prod_new;
   logic [asrms_pkg::SMOOTH_W-1:0] prod_old;
   logic [asrms_pkg::SMOOTH_W-1:0] smooth_sum;
   logic [asrms_pkg::SAMPLE_W-1:0] smoothed;
   logic                           last;

   // A request is taken whenever the queue has room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // One-pole low-pass filter; alpha saturates at unity.
   assign alpha_sat  = (cfg.smoothing_alpha > asrms_pkg::ALPHA_W'(asrms_pkg::ALPHA_ONE)) ?
                       asrms_pkg::ALPHA_W'(asrms_pkg::ALPHA_ONE) : cfg.smoothing_alpha;
   assign alpha_inv  = asrms_pkg::ALPHA_W'(asrms_pkg::ALPHA_ONE) - alpha_sat;
   assign prod_new   = asrms_pkg::SMOOTH_W'(alpha_sat) * asrms_pkg::SMOOTH_W'(req_sample);
   assign prod_old   = asrms_pkg::SMOOTH_W'(alpha_inv) * asrms_pkg::SMOOTH_W'(prev_ff);
   assign smooth_sum = prod_new + prod_old;

   // The first sample of a frame, and every sample while smoothing is off, bypasses the filter.
   always_comb begin
      if (cfg.enable_smoothing && (pos_ff != '0)) begin
         smoothed = smooth_sum[asrms_pkg::SAMPLE_W+7:8];
      end else begin
         smoothed = req_sample;
      end
   end

   assign last = (pos_ff == asrms_pkg::POS_W'(asrms_pkg::FRAME_SAMPLES - 1));

   assign q_entry.smoothed = smoothed;
   assign q_entry.last     = last;

   // Filter history and frame position advance on each accepted request.
   always_comb begin
      prev_in = prev_ff;
      pos_in  = pos_ff;
      if (q_push) begin
         prev_in = smoothed;
         pos_in  = last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         pos_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

>>> rtl/core/asrms_queue.sv
// Small request queue between the front end and the back end.
module asrms_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  asrms_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output asrms_pkg::entry_type pop_entry,
   output logic                 empty
);

   asrms_pkg::entry_type          mem_ff [asrms_pkg::QUEUE_DEPTH];
   logic [asrms_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [asrms_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [asrms_pkg::QPTR_W:0]    count_ff, count_in;

   assign full      = (count_ff == (asrms_pkg::QPTR_W + 1)'(asrms_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/asrms_back.sv
// Back end: compression, square accumulation and the frame-end RMS and level sequencer.
module asrms_back (
   input  logic                                clock,
   input  logic                                reset,
   input  asrms_pkg::cfg_type                  cfg,
   input  logic                                q_empty,
   input  asrms_pkg::entry_type                q_entry,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [asrms_pkg::SAMPLE_W-1:0]      rsp_processed_sample,
   output logic                                rsp_frame_done,
   output logic [asrms_pkg::SAMPLE_W-1:0]      rsp_rms_level,
   output logic [asrms_pkg::SAMPLE_W-1:0]      rsp_intensity
);

   localparam int SW = asrms_pkg::SAMPLE_W;
   localparam int RAD_W = asrms_pkg::SQUARE_W;

   asrms_pkg::back_state_type     state_ff, state_in;
   logic [asrms_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]                 c_ff, c_in;
   logic                          last_ff, last_in;
   logic [asrms_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [RAD_W-1:0]              rad_ff, rad_in;
   logic [SW-1:0]                 root_ff, root_in;
   logic [SW:0]                   srem_ff, srem_in;
   logic [SW-1:0]                 lquo_ff, lquo_in;
   logic [SW-1:0]                 lrem_ff, lrem_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                 rsp_sample_ff, rsp_sample_in;
   logic                          rsp_done_ff, rsp_done_in;
   logic [SW-1:0]                 rsp_rms_ff, rsp_rms_in;
   logic [SW-1:0]                 rsp_level_ff, rsp_level_in;

   logic [SW-1:0]                 compressed;
   logic [SW-1:0]                 excess;
   logic [RAD_W-1:0]              square;
   logic [asrms_pkg::SUM_W-1:0]   sum_next;
   logic [SW+2:0]                 scur;
   logic [SW+2:0]                 strial;
   logic [SW+2:0]                 sdiff;
   logic                          sge;
   logic [SW-1:0]                 root_next;
   logic [SW:0]                   ltrial;
   logic [SW:0]                   ldiv;
   logic [SW:0]                   ldiff;
   logic                          lge;
   logic [SW-1:0]                 lquo_next;
   logic [SW-1:0]                 step;

   // Hard-knee compressor on the queued sample.
   assign excess = q_entry.smoothed - cfg.compress_threshold;
   always_comb begin
      if (cfg.enable_compression && (q_entry.smoothed > cfg.compress_threshold)) begin
         compressed = cfg.compress_threshold + (excess >> 1);
      end else begin
         compressed = q_entry.smoothed;
      end
   end

   // Square and running sum.
   assign square   = RAD_W'(c_ff) * RAD_W'(c_ff);
   assign sum_next = sum_ff + asrms_pkg::SUM_W'(square);

   // One digit step of the square root.
   assign scur      = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign strial    = {1'b0, root_ff, 2'b01};
   assign sge       = (scur >= strial);
   assign sdiff     = scur - strial;
   assign root_next = {root_ff[SW-2:0], sge};

   // One restoring step of the level division; a zero step counts as one.
   assign step      = (cfg.intensity_step == '0) ? SW'(1) : cfg.intensity_step;
   assign ltrial    = {lrem_ff, lquo_ff[SW-1]};
   assign ldiv      = {1'b0, step};
   assign lge       = (ltrial >= ldiv);
   assign ldiff     = ltrial - ldiv;
   assign lquo_next = {lquo_ff[SW-2:0], lge};

   // Sequencer: next state, datapath and result register loads.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      sum_in        = sum_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      srem_in       = srem_ff;
      lquo_in       = lquo_ff;
      lrem_in       = lrem_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_rms_in    = rsp_rms_ff;
      rsp_level_in  = rsp_level_ff;
      unique case (state_ff)
         asrms_pkg::BK_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               c_in     = compressed;
               last_in  = q_entry.last;
               state_in = asrms_pkg::BK_SQUARE;
            end
         end
         asrms_pkg::BK_SQUARE: begin
            if (last_ff) begin
               // The mean square is the frame sum divided by the frame length, a right shift by POS_W.
               rad_in   = sum_next[asrms_pkg::SUM_W-1:asrms_pkg::POS_W];
               root_in  = '0;
               srem_in  = '0;
               sum_in   = '0;
               cnt_in   = asrms_pkg::CNT_W'(asrms_pkg::ROOT_STEPS - 1);
               state_in = asrms_pkg::BK_ROOT;
            end else begin
               sum_in        = sum_next;
               rsp_valid_in  = 1'b1;
               rsp_sample_in = c_ff;
               rsp_done_in   = 1'b0;
               rsp_rms_in    = '0;
               rsp_level_in  = '0;
               state_in      = asrms_pkg::BK_IDLE;
            end
         end
         asrms_pkg::BK_ROOT: begin
            srem_in = sge ? sdiff[SW:0] : scur[SW:0];
            root_in = root_next;
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            if (cnt_ff == '0) begin
               lquo_in  = (root_next == '0) ? '0 : root_next - 1'b1;
               lrem_in  = '0;
               cnt_in   = asrms_pkg::CNT_W'(asrms_pkg::LEVEL_STEPS - 1);
               state_in = asrms_pkg::BK_LEVEL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         asrms_pkg::BK_LEVEL: begin
            lrem_in = lge ? ldiff[SW-1:0] : ltrial[SW-1:0];
            lquo_in = lquo_next;
            if (cnt_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = c_ff;
               rsp_done_in   = 1'b1;
               rsp_rms_in    = root_ff;
               rsp_level_in  = lquo_next;
               state_in      = asrms_pkg::BK_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = asrms_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asrms_pkg::BK_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload registers.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      c_ff          <= c_in;
      last_ff       <= last_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      srem_ff       <= srem_in;
      lquo_ff       <= lquo_in;
      lrem_ff       <= lrem_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_rms_ff    <= rsp_rms_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_processed_sample = rsp_sample_ff;
   assign rsp_frame_done       = rsp_done_ff;
   assign rsp_rms_level        = rsp_rms_ff;
   assign rsp_intensity        = rsp_level_ff;

`ifndef ASSERT_OFF
   // The result register stays empty while the frame-end sequence runs.
   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asrms_pkg::BK_ROOT || state_ff == asrms_pkg::BK_LEVEL) |-> !rsp_valid_ff)
      else $error("result pending during frame-end sequence");

   // The last level step always delivers a frame-done result.
   a_level_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asrms_pkg::BK_LEVEL && cnt_ff == '0) |=> (rsp_valid_ff && rsp_done_ff))
      else $error("frame end did not produce a frame-done result");

   // The accumulator is cleared as soon as a frame closes.
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asrms_pkg::BK_ROOT) |-> (sum_ff == '0))
      else $error("square sum not cleared at frame end");

   // Mid-frame results carry no level information.
   a_midframe_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |-> (rsp_rms_ff == '0 && rsp_level_ff == '0))
      else $error("mid-frame result carries RMS or intensity");
`endif

endmodule

>>> rtl/core/audio_smooth_compress_rms_meter.sv
// A mid-frame request passes through the queue, the back end's sample register and the result
// register before its result appears. A frame's last request adds 12 square-root and 12
// level-division steps. Inside a frame the back end sequencer takes a new request only once
// each result has left; a frame's last request holds the back end through all of those steps.
// The 4-entry queue keeps taking requests, until it is full, while a result waits or a frame closes.
// Reset is synchronous and active high; it restores register defaults and clears state.
module audio_smooth_compress_rms_meter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [asrms_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [asrms_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [asrms_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [asrms_pkg::SAMPLE_W-1:0]         rsp_processed_sample,
   output logic                                   rsp_frame_done,
   output logic [asrms_pkg::SAMPLE_W-1:0]         rsp_rms_level,
   output logic [asrms_pkg::SAMPLE_W-1:0]         rsp_intensity
);

   asrms_pkg::cfg_type   cfg_ff, cfg_in;
   asrms_pkg::entry_type push_entry;
   asrms_pkg::entry_type pop_entry;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;

   // Register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            asrms_pkg::CSR_ENABLE_SMOOTHING:   cfg_in.enable_smoothing   = csr_wdata[0];
            asrms_pkg::CSR_SMOOTHING_ALPHA:
               cfg_in.smoothing_alpha = csr_wdata[asrms_pkg::ALPHA_W-1:0];
            asrms_pkg::CSR_ENABLE_COMPRESSION: cfg_in.enable_compression = csr_wdata[0];
            asrms_pkg::CSR_COMPRESS_THRESHOLD: cfg_in.compress_threshold = csr_wdata;
            asrms_pkg::CSR_INTENSITY_STEP:     cfg_in.intensity_step     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_smoothing   <= 1'b1;
         cfg_ff.smoothing_alpha    <= asrms_pkg::ALPHA_W'(128);
         cfg_ff.enable_compression <= 1'b1;
         cfg_ff.compress_threshold <= asrms_pkg::SAMPLE_W'(2048);
         cfg_ff.intensity_step     <= asrms_pkg::SAMPLE_W'(819);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: smoothing and framing.
   asrms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   // Decoupling queue.
   asrms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // Back end: compression, accumulation and frame statistics.
   asrms_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_empty              (q_empty),
      .q_entry              (pop_entry),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_processed_sample (rsp_processed_sample),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_rms_level        (rsp_rms_level),
      .rsp_intensity        (rsp_intensity)
   );

endmodule

>>> verif/audio_smooth_compress_rms_meter_tb.sv
// Self-checking testbench for the audio RMS level meter with smoothing and compression.
`timescale 1ns / 100ps

module audio_smooth_compress_rms_meter_tb;

   localparam int                  SAMPLE_W      = asrms_pkg::SAMPLE_W;
   localparam int                  CSR_INDEX_W   = asrms_pkg::CSR_INDEX_W;
   localparam int                  CSR_DATA_W    = asrms_pkg::CSR_DATA_W;
   localparam int                  ALPHA_W       = asrms_pkg::ALPHA_W;
   localparam int                  ALPHA_ONE     = asrms_pkg::ALPHA_ONE;
   localparam int                  FRAME_SAMPLES = asrms_pkg::FRAME_SAMPLES;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = {SAMPLE_W{1'b1}};
   localparam int                  DRAIN_CYCLES  = 80;
   localparam int                  MAX_REPORTS   = 10;

   // One reading as the meter reports it for one request.
   typedef struct packed {
      logic [SAMPLE_W-1:0] processed;
      logic                frame_done;
      logic [SAMPLE_W-1:0] rms;
      logic [SAMPLE_W-1:0] level;
   } meter_reading_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_processed_sample;
   logic                   rsp_frame_done;
   logic [SAMPLE_W-1:0]    rsp_rms_level;
   logic [SAMPLE_W-1:0]    rsp_intensity;

   // Predictor state: register copy, filter memory, frame energy and position.
   asrms_pkg::cfg_type  meter_cfg;
   logic [SAMPLE_W-1:0] last_smoothed;
   longint unsigned     energy_sum;
   int                  frame_pos;

   meter_reading_type   pending_readings[$];
   meter_reading_type   want;
   meter_reading_type   got;
   int                  mismatch_count = 0;
   int                  stall_left = 0;
   bit                  calm = 1'b0;

   audio_smooth_compress_rms_meter dut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_processed_sample (rsp_processed_sample),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_rms_level        (rsp_rms_level),
      .rsp_intensity        (rsp_intensity)
   );

   always #5 clock = ~clock;

   // Works out the reading for one sample and advances the predictor state.
   function automatic meter_reading_type predict_reading(input logic [SAMPLE_W-1:0] x);
      meter_reading_type   r;
      logic [SAMPLE_W-1:0] y;
      logic [SAMPLE_W-1:0] c;
      int unsigned         a;
      int unsigned         mix;
      int unsigned         step;
      longint unsigned     mean;
      longint unsigned     root;
      longint unsigned     trial;
      r = '0;
      y = x;
      // The first sample of a frame, and every sample with smoothing off, bypasses the low-pass filter.
      if (meter_cfg.enable_smoothing && frame_pos != 0) begin
         a = (meter_cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : meter_cfg.smoothing_alpha;
         mix = a * x + (ALPHA_ONE - a) * last_smoothed;
         y = SAMPLE_W'(mix >> $clog2(ALPHA_ONE));
      end
      last_smoothed = y;

      // Hard knee: half of the excess above the threshold survives.
      c = y;
      if (meter_cfg.enable_compression && y > meter_cfg.compress_threshold) begin
         c = meter_cfg.compress_threshold + ((y - meter_cfg.compress_threshold) >> 1);
      end
      r.processed = c;
      energy_sum += longint'(c) * longint'(c);
      frame_pos++;

      // Frame end: floor root of the floored mean, then the step count below it.
      if (frame_pos >= FRAME_SAMPLES) begin
         mean = energy_sum / FRAME_SAMPLES;
         root = 0;
         for (int b = SAMPLE_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= mean) begin
               root = trial;
            end
         end
         step = (meter_cfg.intensity_step == 0) ? 1 : meter_cfg.intensity_step;
         r.frame_done = 1'b1;
         r.rms = SAMPLE_W'(root);
         r.level = (root == 0) ? '0 : SAMPLE_W'((root - 1) / step);
         energy_sum = 0;
         frame_pos = 0;
      end
      return r;
   endfunction

   // Mix of full-range, rail, near-knee and quiet samples.
   function automatic logic [SAMPLE_W-1:0] random_sample();
      int v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         1: begin
            v = int'(meter_cfg.compress_threshold) + int'($urandom_range(0, 16)) - 8;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
         end
         2: v = $urandom_range(0, 63);
         default: v = $urandom_range(0, SAMPLE_MAX);
      endcase
      return SAMPLE_W'(v);
   endfunction

   // Writes one register and mirrors the write into the predictor copy.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         asrms_pkg::CSR_ENABLE_SMOOTHING:   meter_cfg.enable_smoothing   = data[0];
         asrms_pkg::CSR_SMOOTHING_ALPHA:    meter_cfg.smoothing_alpha    = data[ALPHA_W-1:0];
         asrms_pkg::CSR_ENABLE_COMPRESSION: meter_cfg.enable_compression = data[0];
         asrms_pkg::CSR_COMPRESS_THRESHOLD:
            meter_cfg.compress_threshold = data[SAMPLE_W-1:0];
         asrms_pkg::CSR_INTENSITY_STEP:     meter_cfg.intensity_step     = data[SAMPLE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Programs every register, plus one write to an unused index that must be ignored.
   task automatic set_meter(input logic smooth_on, input logic [CSR_DATA_W-1:0] alpha,
                            input logic comp_on, input logic [CSR_DATA_W-1:0] threshold,
                            input logic [CSR_DATA_W-1:0] step);
      write_reg(asrms_pkg::CSR_ENABLE_SMOOTHING, {(CSR_DATA_W - 1)'($urandom()), smooth_on});
      write_reg(asrms_pkg::CSR_SMOOTHING_ALPHA, alpha);
      write_reg(asrms_pkg::CSR_ENABLE_COMPRESSION, {(CSR_DATA_W - 1)'($urandom()), comp_on});
      write_reg(asrms_pkg::CSR_COMPRESS_THRESHOLD, threshold);
      write_reg(asrms_pkg::CSR_INTENSITY_STEP, step);
      write_reg(CSR_INDEX_W'($urandom_range(int'(asrms_pkg::CSR_INTENSITY_STEP) + 1,
                                            (1 << CSR_INDEX_W) - 1)),
                CSR_DATA_W'($urandom()));
   endtask

   // Sends one request, with an occasional gap before it, and records its reading.
   task automatic send_sample(input logic [SAMPLE_W-1:0] x);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= x;
      pending_readings.push_back(predict_reading(x));
      do @(posedge clock); while (req_stall);
   endtask

   // Holds off the sender until every reading is back and the block has settled.
   task automatic drain_meter();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Rails, the knee at reset defaults and alternating bit patterns.
   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] pattern[$];
      pattern = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2047, 12'd2048, 12'd2049,
                  12'd2050, 12'h555, 12'hAAA, 12'd4095, 12'd4095, 12'd0, 12'd0,
                  12'h800, 12'h7FF, 12'd100, 12'd3000, 12'd4095, 12'd1, 12'hF0F,
                  12'h0F0, 12'd2048, 12'd4095, 12'd0};
      foreach (pattern[i]) send_sample(pattern[i]);
      drain_meter();
   endtask

   // Several register settings mid-frame, the extremes first.
   task automatic test_register_settings();
      for (int s = 0; s < 8; s++) begin
         case (s)
            0: set_meter(1'b0, '0, 1'b0, '0, '0);
            1: set_meter(1'b1, '0, 1'b1, '0, CSR_DATA_W'(1));
            2: set_meter(1'b1, CSR_DATA_W'(ALPHA_ONE), 1'b1, SAMPLE_MAX, SAMPLE_MAX);
            3: set_meter(1'b1, {CSR_DATA_W{1'b1}}, 1'b0, CSR_DATA_W'(2048),
                         CSR_DATA_W'(819));
            4: set_meter(1'b1, CSR_DATA_W'(ALPHA_ONE + 1), 1'b1, CSR_DATA_W'(1), SAMPLE_MAX);
            5: set_meter(1'b0, CSR_DATA_W'($urandom()), 1'b1, CSR_DATA_W'($urandom()),
                         CSR_DATA_W'($urandom()));
            default: set_meter(1'($urandom_range(0, 1)), CSR_DATA_W'($urandom()),
                               1'($urandom_range(0, 1)), CSR_DATA_W'($urandom()),
                               CSR_DATA_W'($urandom()));
         endcase
         calm = ($urandom_range(0, 3) == 0);
         repeat (50) send_sample(random_sample());
         drain_meter();
      end
      calm = 1'b0;
   endtask

   // Back-to-back requests with no idling on either side to close the run.
   task automatic test_steady_stream();
      calm = 1'b1;
      repeat (25) send_sample(random_sample());
      drain_meter();
   endtask

   // Result checking and receiver stall bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_processed_sample, rsp_frame_done, rsp_rms_level, rsp_intensity};
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result sample %0d done %0d rms %0d level %0d",
                        $realtime, got.processed, got.frame_done, got.rms, got.level);
            end
         end else begin
            want = pending_readings.pop_front();
            if (got.processed !== want.processed || got.frame_done !== want.frame_done ||
                got.rms !== want.rms || got.level !== want.level) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch expected sample %0d done %0d rms %0d level %0d",
                           $realtime, want.processed, want.frame_done, want.rms, want.level);
                  $display("%0t:          got      sample %0d done %0d rms %0d level %0d",
                           $realtime, got.processed, got.frame_done, got.rms, got.level);
               end
            end
         end
      end

      if (reset || calm) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Main sequence.
   initial begin
      meter_cfg.enable_smoothing   = 1'b1;
      meter_cfg.smoothing_alpha    = ALPHA_W'(128);
      meter_cfg.enable_compression = 1'b1;
      meter_cfg.compress_threshold = SAMPLE_W'(2048);
      meter_cfg.intensity_step     = SAMPLE_W'(819);
      last_smoothed = '0;
      energy_sum    = 0;
      frame_pos     = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sample_extremes();
      test_register_settings();
      test_steady_stream();

      if (mismatch_count == 0) begin
         $display("PASS audio_smooth_compress_rms_meter");
      end else begin
         $display("FAIL audio_smooth_compress_rms_meter");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("FAIL audio_smooth_compress_rms_meter");
      $finish;
   end

endmodule

>>> audio_smooth_compress_rms_meter.f
rtl/core/asrms_pkg.sv
rtl/core/asrms_front.sv
rtl/core/asrms_queue.sv
rtl/core/asrms_back.sv
rtl/core/audio_smooth_compress_rms_meter.sv
verif/audio_smooth_compress_rms_meter_tb.sv
